// ===== hw/rtl/overwrite_ring_buffer_with_window_mean_macros.svh =====
// Assertion macros for the ring buffer block.
`ifndef OVERWRITE_RING_BUFFER_WITH_WINDOW_MEAN_MACROS_SVH
`define OVERWRITE_RING_BUFFER_WITH_WINDOW_MEAN_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ORBWM_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("orbwm: same-cycle check failed");

// Next-cycle implication.
`define ORBWM_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("orbwm: next-cycle check failed");

`else

`define ORBWM_ASSERT_IMP(label, ante, cons)
`define ORBWM_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/orbwm_pkg.sv =====
package orbwm_pkg;

   localparam int DEPTH_DEF = 64;

   localparam int CMD_W    = 3;
   localparam int SAMPLE_W = 16;
   localparam int BACK_W   = 6;
   localparam int WIN_W    = 7;
   localparam int VALUE_W  = 17;
   localparam int HEAD_W   = 6;
   localparam int FILL_W   = 7;

   // window_len * |sample| fits in VALUE_W + WIN_W bits
   localparam int SUM_W    = VALUE_W + WIN_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT   = 3'd0,
      CMD_GET   = 3'd1,
      CMD_PEEK  = 3'd2,
      CMD_MEAN  = 3'd3,
      CMD_CLEAR = 3'd4
   } cmd_type;

endpackage

// ===== hw/rtl/orbwm_ifs.sv =====
interface orbwm_req_if;
   logic                                 valid;
   logic                                 ready;
   logic        [orbwm_pkg::CMD_W-1:0]    cmd;
   logic signed [orbwm_pkg::SAMPLE_W-1:0] sample;
   logic        [orbwm_pkg::BACK_W-1:0]   lookback;
   logic        [orbwm_pkg::WIN_W-1:0]    window_len;

   modport source (output valid, cmd, sample, lookback, window_len, input ready);
   modport sink   (input valid, cmd, sample, lookback, window_len, output ready);
endinterface

interface orbwm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [orbwm_pkg::VALUE_W-1:0] value;
   logic                                error;
   logic        [orbwm_pkg::HEAD_W-1:0]  head_index;
   logic        [orbwm_pkg::FILL_W-1:0]  fill_count;
   logic                                is_full;
   logic                                is_empty;

   modport source (output valid, value, error, head_index, fill_count, is_full, is_empty,
                   input ready);
   modport sink   (input valid, value, error, head_index, fill_count, is_full, is_empty,
                   output ready);
endinterface

// ===== hw/rtl/overwrite_ring_buffer_with_window_mean.sv =====
// Overwrite-oldest ring buffer of Q7.8 samples with a windowed mean of magnitudes.
// req_chan (sink) takes one command word: put, get oldest, peek back, mean of the
// newest window_len samples, or clear. rsp_chan (source) returns one word per
// command: value, error, and head index, fill count, full and empty after it.
// One command is in work at a time; req_chan.ready is high only while idle.
// Put, clear, unknown commands and errors go straight to the response load.
// Get and peek pass through fetch and read states (one registered read of the sample RAM).
// Mean of n samples: the RAM is walked one sample a cycle into a shared
// 25-bit adder, which then runs a 24-step shift/subtract divide.
// Next command is taken in the cycle after the response is loaded.
// The response sits in an output register; a stalled receiver holds it while
// the next command is accepted and worked, and only the final load waits.
// Reset (synchronous) empties the buffer and drops any pending response.
// Sample RAM contents are not cleared; only stored samples are ever read.
`include "overwrite_ring_buffer_with_window_mean_macros.svh"

module overwrite_ring_buffer_with_window_mean #(
   parameter int DEPTH = orbwm_pkg::DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   orbwm_req_if.sink    req_chan,
   orbwm_rsp_if.source  rsp_chan
);

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > orbwm_pkg::WIN_W) ? CNT_W : orbwm_pkg::WIN_W;
   localparam int SL_W   = CMP_W + 1;
   localparam int SUM_W  = orbwm_pkg::SUM_W;
   localparam int WIN_W  = orbwm_pkg::WIN_W;
   localparam int VAL_W  = orbwm_pkg::VALUE_W;
   localparam int SMP_W  = orbwm_pkg::SAMPLE_W;
   localparam int STEP_W = $clog2(SUM_W + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_FETCH = 6'b000010,
      S_READ  = 6'b000100,
      S_ACC   = 6'b001000,
      S_DIV   = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic                     full_ff, full_in;
   logic [PTR_W-1:0]         addr_ff, addr_in;
   logic [SMP_W-1:0]         rd_data_ff;
   logic                     mean_ff, mean_in;
   logic [WIN_W-1:0]         win_ff, win_in;
   logic [WIN_W-1:0]         left_ff, left_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [WIN_W:0]           rem_ff, rem_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [VAL_W-1:0]         value_ff, value_in;
   logic                     err_ff, err_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]         rsp_value_ff;
   logic                     rsp_error_ff;
   logic [orbwm_pkg::HEAD_W-1:0] rsp_head_ff;
   logic [orbwm_pkg::FILL_W-1:0] rsp_fill_ff;
   logic                     rsp_full_ff;
   logic                     rsp_empty_ff;

   logic [SMP_W-1:0]         mem [DEPTH];

   logic                     accept;
   logic                     mem_wr;
   logic                     rsp_load;
   logic [CNT_W-1:0]         count;
   logic [SL_W-1:0]          slot_raw;
   logic [SL_W-1:0]          slot_wrap;
   logic [PTR_W-1:0]         slot;
   logic [PTR_W-1:0]         newest;
   logic [PTR_W-1:0]         addr_dec;
   logic [VAL_W-1:0]         smp_ext;
   logic [VAL_W-1:0]         smp_abs;
   logic [WIN_W:0]           rem_sh;
   logic                     alu_sub;
   logic [SUM_W:0]           alu_a, alu_b, alu_res;
   logic                     q_bit;
   logic [SUM_W-1:0]         quot_next;

   assign accept           = req_chan.valid && (state_ff == S_IDLE);
   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_load         = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.value      = signed'(rsp_value_ff);
   assign rsp_chan.error      = rsp_error_ff;
   assign rsp_chan.head_index = rsp_head_ff;
   assign rsp_chan.fill_count = rsp_fill_ff;
   assign rsp_chan.is_full    = rsp_full_ff;
   assign rsp_chan.is_empty   = rsp_empty_ff;

   always_comb begin
      if (full_ff) begin
         count = CNT_W'(DEPTH);
      end else if (wr_ptr_ff >= rd_ptr_ff) begin
         count = CNT_W'(wr_ptr_ff) - CNT_W'(rd_ptr_ff);
      end else begin
         count = CNT_W'(DEPTH) + CNT_W'(wr_ptr_ff) - CNT_W'(rd_ptr_ff);
      end
   end

   // slot lookback places behind the newest sample
   assign slot_raw  = SL_W'(wr_ptr_ff) + SL_W'(DEPTH) - SL_W'(1)
                      - SL_W'(req_chan.lookback);
   assign slot_wrap = (slot_raw >= SL_W'(DEPTH)) ? (slot_raw - SL_W'(DEPTH)) : slot_raw;
   assign slot      = PTR_W'(slot_wrap);
   assign newest    = (wr_ptr_ff == '0) ? PTR_LAST : (wr_ptr_ff - PTR_W'(1));
   assign addr_dec  = (addr_ff == '0) ? PTR_LAST : (addr_ff - PTR_W'(1));

   assign smp_ext = {rd_data_ff[SMP_W-1], rd_data_ff};
   assign smp_abs = rd_data_ff[SMP_W-1] ? (VAL_W'(0) - smp_ext) : smp_ext;
   assign rem_sh  = {rem_ff[WIN_W-1:0], sum_ff[SUM_W-1]};

   // shared adder: accumulate magnitudes, then trial subtract for the divide
   always_comb begin
      if (state_ff == S_DIV) begin
         alu_sub = 1'b1;
         alu_a   = (SUM_W + 1)'(rem_sh);
         alu_b   = (SUM_W + 1)'(win_ff);
      end else begin
         alu_sub = 1'b0;
         alu_a   = {1'b0, sum_ff};
         alu_b   = (SUM_W + 1)'(smp_abs);
      end
      alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
   end

   assign q_bit     = !alu_res[SUM_W];
   assign quot_next = {sum_ff[SUM_W-2:0], q_bit};

   always_comb begin
      state_in = state_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      full_in = full_ff;
      addr_in = addr_ff;
      mean_in = mean_ff;
      win_in = win_ff;
      left_in = left_ff;
      sum_in = sum_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      value_in = value_ff;
      err_in = err_ff;
      mem_wr = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               value_in = '0;
               err_in   = 1'b0;
               mean_in  = 1'b0;
               win_in   = req_chan.window_len;
               state_in = S_DONE;
               case (req_chan.cmd)
                  orbwm_pkg::CMD_PUT: begin
                     mem_wr = 1'b1;
                     if (full_ff) begin
                        rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : (rd_ptr_ff + PTR_W'(1));
                     end
                     wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : (wr_ptr_ff + PTR_W'(1));
                     full_in   = (wr_ptr_in == rd_ptr_in);
                  end
                  orbwm_pkg::CMD_GET: begin
                     if (count == '0) begin
                        err_in = 1'b1;
                     end else begin
                        addr_in   = rd_ptr_ff;
                        full_in   = 1'b0;
                        rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : (rd_ptr_ff + PTR_W'(1));
                        state_in  = S_FETCH;
                     end
                  end
                  orbwm_pkg::CMD_PEEK: begin
                     if (CMP_W'(req_chan.lookback) >= CMP_W'(count)) begin
                        err_in = 1'b1;
                     end else begin
                        addr_in  = slot;
                        state_in = S_FETCH;
                     end
                  end
                  orbwm_pkg::CMD_MEAN: begin
                     if (CMP_W'(req_chan.window_len) > CMP_W'(count)) begin
                        err_in = 1'b1;
                     end else if (req_chan.window_len != '0) begin
                        addr_in  = newest;
                        mean_in  = 1'b1;
                        left_in  = req_chan.window_len;
                        sum_in   = '0;
                        state_in = S_FETCH;
                     end
                  end
                  orbwm_pkg::CMD_CLEAR: begin
                     wr_ptr_in = '0;
                     rd_ptr_in = '0;
                     full_in   = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FETCH: begin
            addr_in  = addr_dec;
            state_in = mean_ff ? S_ACC : S_READ;
         end
         S_READ: begin
            value_in = smp_ext;
            state_in = S_DONE;
         end
         S_ACC: begin
            sum_in  = alu_res[SUM_W-1:0];
            addr_in = addr_dec;
            left_in = left_ff - WIN_W'(1);
            if (left_ff == WIN_W'(1)) begin
               rem_in   = '0;
               step_in  = STEP_W'(SUM_W);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = q_bit ? alu_res[WIN_W:0] : rem_sh;
            sum_in  = quot_next;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               value_in = VAL_W'(quot_next);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[wr_ptr_ff] <= req_chan.sample;
      end
      rd_data_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      mean_ff  <= mean_in;
      win_ff   <= win_in;
      left_ff  <= left_in;
      sum_ff   <= sum_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      value_ff <= value_in;
      err_ff   <= err_in;
      if (rsp_load) begin
         rsp_value_ff <= value_ff;
         rsp_error_ff <= err_ff;
         rsp_head_ff  <= orbwm_pkg::HEAD_W'(wr_ptr_ff);
         rsp_fill_ff  <= orbwm_pkg::FILL_W'(count);
         rsp_full_ff  <= full_ff;
         rsp_empty_ff <= (count == '0);
      end
   end

   `ORBWM_ASSERT_IMP(a_full_ptrs, full_ff, wr_ptr_ff == rd_ptr_ff)
   `ORBWM_ASSERT_IMP(a_err_zero, rsp_valid_ff && rsp_error_ff, rsp_value_ff == '0)
   `ORBWM_ASSERT_NXT(a_busy_after_accept, accept, !req_chan.ready)
   `ORBWM_ASSERT_IMP(a_acc_left, state_ff == S_ACC, left_ff != '0)

endmodule

// ===== tb/orbwm_status_checker.sv =====
module orbwm_status_checker
   import orbwm_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   orbwm_req_if  req_chan,
   orbwm_rsp_if  rsp_chan,
   output int    failures,
   output int    awaiting
);

   localparam int DEPTH = DEPTH_DEF;

   typedef struct {
      logic [CMD_W-1:0]          cmd;
      logic signed [VALUE_W-1:0] value;
      logic                      error;
      logic [HEAD_W-1:0]         head_index;
      logic [FILL_W-1:0]         fill_count;
      logic                      is_full;
      logic                      is_empty;
   } ring_status_type;

   logic signed [SAMPLE_W-1:0] slots [DEPTH];
   logic [HEAD_W-1:0]          head_pos;
   logic [HEAD_W-1:0]          tail_pos;
   logic                       wrapped;
   ring_status_type            expected_status [$];
   int                         mismatches = 0;

   function automatic int occupancy();
      logic [HEAD_W-1:0] diff;
      diff = head_pos - tail_pos;
      return wrapped ? DEPTH : int'(diff);
   endfunction

   task automatic apply_command(input logic [CMD_W-1:0] cmd,
                                input logic signed [SAMPLE_W-1:0] smp,
                                input logic [BACK_W-1:0] back,
                                input logic [WIN_W-1:0] win,
                                output ring_status_type st);
      int count;
      int total;
      int mag;
      logic [HEAD_W-1:0] idx;
      count = occupancy();
      st.cmd = cmd;
      st.value = '0;
      st.error = 1'b0;
      case (cmd)
         CMD_PUT: begin
            slots[head_pos] = smp;
            if (wrapped) tail_pos = tail_pos + 6'd1;
            head_pos = head_pos + 6'd1;
            wrapped = (head_pos == tail_pos);
         end
         CMD_GET: begin
            if (count == 0) begin
               st.error = 1'b1;
            end else begin
               st.value = slots[tail_pos];
               wrapped = 1'b0;
               tail_pos = tail_pos + 6'd1;
            end
         end
         CMD_PEEK: begin
            if (int'(back) >= count) begin
               st.error = 1'b1;
            end else begin
               idx = head_pos - 6'd1 - back;
               st.value = slots[idx];
            end
         end
         CMD_MEAN: begin
            if (int'(win) > count) begin
               st.error = 1'b1;
            end else if (win != 0) begin
               total = 0;
               for (int k = 0; k < int'(win); k++) begin
                  idx = head_pos - 6'd1 - k[HEAD_W-1:0];
                  mag = slots[idx];
                  total += (mag < 0) ? -mag : mag;
               end
               st.value = VALUE_W'(total / int'(win));
            end
         end
         CMD_CLEAR: begin
            head_pos = '0;
            tail_pos = '0;
            wrapped = 1'b0;
         end
         default: ;
      endcase
      count = occupancy();
      st.head_index = head_pos;
      st.fill_count = FILL_W'(count);
      st.is_full = wrapped;
      st.is_empty = (count == 0);
   endtask

   task automatic compare_field(input logic [CMD_W-1:0] cmd, input string field,
                                input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (got !== want) begin
         $display("%0t: cmd %0d %s expected %0d actual %0d", $time, cmd, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      ring_status_type want;
      if (reset) begin
         head_pos = '0;
         tail_pos = '0;
         wrapped = 1'b0;
         expected_status.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_status.size() == 0) begin
               $display("%0t: unexpected response word, value %0d", $time, rsp_chan.value);
               mismatches++;
            end else begin
               want = expected_status.pop_front();
               compare_field(want.cmd, "value", want.value, rsp_chan.value);
               compare_field(want.cmd, "error", want.error, rsp_chan.error);
               compare_field(want.cmd, "head_index", want.head_index, rsp_chan.head_index);
               compare_field(want.cmd, "fill_count", want.fill_count, rsp_chan.fill_count);
               compare_field(want.cmd, "is_full", want.is_full, rsp_chan.is_full);
               compare_field(want.cmd, "is_empty", want.is_empty, rsp_chan.is_empty);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            apply_command(req_chan.cmd, req_chan.sample, req_chan.lookback,
                          req_chan.window_len, want);
            expected_status.push_back(want);
         end
      end
      awaiting <= expected_status.size();
      failures <= mismatches;
   end

endmodule

// ===== tb/overwrite_ring_buffer_with_window_mean_test.sv =====
module overwrite_ring_buffer_with_window_mean_test;
   import orbwm_pkg::*;

   localparam int WORD_COUNT    = 1800;
   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 120;
   localparam int HOLD_AT       = 300;
   localparam int HOLD_CYCLES   = 400;
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   logic clock = 1'b0;
   logic reset;
   int   failures;
   int   awaiting;
   int   stored = 0;
   int   sent = 0;
   int   quiet = 0;
   bit   steady = 1'b0;

   orbwm_req_if req_chan ();
   orbwm_rsp_if rsp_chan ();

   overwrite_ring_buffer_with_window_mean uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   orbwm_status_checker status_check (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .failures(failures),
      .awaiting(awaiting)
   );

   always #10 clock = ~clock;

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         3: return 16'shffff;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send_word(input logic [CMD_W-1:0] cmd,
                            input logic signed [SAMPLE_W-1:0] smp,
                            input logic [BACK_W-1:0] back,
                            input logic [WIN_W-1:0] win);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(99) < 15)
         gap = ($urandom_range(9) == 0) ? $urandom_range(120, 5) : $urandom_range(4, 1);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd <= cmd;
      req_chan.sample <= smp;
      req_chan.lookback <= back;
      req_chan.window_len <= win;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      case (cmd)
         CMD_PUT: if (stored < DEPTH_DEF) stored++;
         CMD_GET: if (stored > 0) stored--;
         CMD_CLEAR: stored = 0;
         default: ;
      endcase
      sent++;
   endtask

   task automatic random_command();
      int r;
      int back;
      int win;
      r = $urandom_range(99);
      back = (stored > 0 && $urandom_range(9) < 8) ? $urandom_range(stored - 1, 0)
                                                   : $urandom_range(63);
      win = ($urandom_range(9) < 8) ? $urandom_range(stored, 0) : $urandom_range(64);
      if (r < 38)
         send_word(CMD_PUT, pick_sample(), BACK_W'($urandom),
                   WIN_W'($urandom_range(64)));
      else if (r < 52)
         send_word(CMD_GET, SAMPLE_W'($urandom), BACK_W'($urandom),
                   WIN_W'($urandom_range(64)));
      else if (r < 72)
         send_word(CMD_PEEK, SAMPLE_W'($urandom), BACK_W'(back),
                   WIN_W'($urandom_range(64)));
      else if (r < 93)
         send_word(CMD_MEAN, SAMPLE_W'($urandom), BACK_W'($urandom), WIN_W'(win));
      else if (r < 97)
         send_word(CMD_CLEAR, SAMPLE_W'($urandom), BACK_W'($urandom),
                   WIN_W'($urandom_range(64)));
      else
         send_word(CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)),
                   SAMPLE_W'($urandom), BACK_W'($urandom), WIN_W'($urandom_range(64)));
   endtask

   task automatic fill_burst();
      int len;
      bit pinned;
      logic signed [SAMPLE_W-1:0] level;
      pinned = ($urandom_range(7) == 0);
      level = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
      len = pinned ? $urandom_range(80, 64) : $urandom_range(80, 30);
      repeat (len)
         send_word(CMD_PUT, pinned ? level : pick_sample(), BACK_W'($urandom),
                   WIN_W'($urandom_range(64)));
      send_word(CMD_MEAN, SAMPLE_W'($urandom), BACK_W'($urandom), WIN_W'(stored));
      send_word(CMD_PEEK, SAMPLE_W'($urandom), BACK_W'($urandom_range(stored - 1, 0)),
                WIN_W'($urandom_range(64)));
      send_word(CMD_MEAN, SAMPLE_W'($urandom), BACK_W'($urandom),
                WIN_W'($urandom_range(stored, 1)));
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.cmd <= CMD_PUT;
      req_chan.sample <= '0;
      req_chan.lookback <= '0;
      req_chan.window_len <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty store: errors, and a zero-length mean
      send_word(CMD_GET, 16'sh0000, 6'd0, 7'd0);
      send_word(CMD_PEEK, 16'sh0000, 6'd0, 7'd0);
      send_word(CMD_MEAN, 16'sh0000, 6'd0, 7'd0);
      send_word(CMD_MEAN, 16'sh0000, 6'd0, 7'd1);
      send_word(CMD_PUT, 16'sh7fff, 6'd63, 7'd64);
      send_word(CMD_PUT, 16'sh8000, 6'd0, 7'd0);
      send_word(CMD_PUT, 16'sh0000, 6'd21, 7'd42);
      send_word(CMD_PUT, 16'shffff, 6'd42, 7'd21);
      send_word(CMD_PEEK, 16'sh0000, 6'd0, 7'd0);
      send_word(CMD_PEEK, 16'sh0000, 6'd3, 7'd0);
      send_word(CMD_PEEK, 16'sh0000, 6'd4, 7'd0);
      send_word(CMD_PEEK, 16'sh0000, 6'd63, 7'd0);
      send_word(CMD_MEAN, 16'sh0000, 6'd0, 7'd4);
      send_word(CMD_MEAN, 16'sh0000, 6'd0, 7'd5);
      send_word(CMD_MEAN, 16'sh0000, 6'd0, 7'd64);
      send_word(CMD_GET, 16'sh0000, 6'd0, 7'd0);
      send_word(CMD_SPARE_LO, 16'sh1234, 6'd5, 7'd5);
      send_word(CMD_SPARE_HI, 16'sh4321, 6'd1, 7'd1);
      send_word(CMD_CLEAR, 16'sh0000, 6'd0, 7'd0);
      send_word(CMD_GET, 16'sh0000, 6'd0, 7'd0);
      send_word(CMD_PEEK, 16'sh0000, 6'd0, 7'd0);
      send_word(CMD_PUT, 16'sh5555, 6'd0, 7'd0);
      send_word(CMD_PUT, 16'shaaaa, 6'd0, 7'd0);
      send_word(CMD_MEAN, 16'sh0000, 6'd0, 7'd2);

      while (sent < WORD_COUNT) begin
         steady = (sent >= 700 && sent < 1000);
         case ($urandom_range(19))
            0: fill_burst();
            1: repeat (stored + $urandom_range(3))
                  send_word(CMD_GET, SAMPLE_W'($urandom), BACK_W'($urandom),
                            WIN_W'($urandom_range(64)));
            default: random_command();
         endcase
      end
      steady = 1'b0;

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && awaiting == 0)
         $display("overwrite_ring_buffer_with_window_mean test passed");
      else
         $display("overwrite_ring_buffer_with_window_mean test failed");
      $finish;
   end

   // long receiver hold-off once, so the block backs up into the input
   initial begin
      bit held;
      held = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && sent >= HOLD_AT) begin
            held = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_chan.ready <= steady || ($urandom_range(99) >= 15);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet == STALL_LIMIT) begin
         $display("overwrite_ring_buffer_with_window_mean test failed");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/orbwm_pkg.sv
hw/rtl/orbwm_ifs.sv
hw/rtl/overwrite_ring_buffer_with_window_mean.sv
tb/orbwm_status_checker.sv
tb/overwrite_ring_buffer_with_window_mean_test.sv
